// File: hw/rtl/qibn_pkg.sv
// ----------------------------------------------------------------------------
// qibn_pkg
// Shared widths, codes and result types of the inverse bilinear Newton unit.
// ----------------------------------------------------------------------------
package qibn_pkg;

  localparam int CMD_W   = 3;
  localparam int AXIS_W  = 2;
  localparam int IT_W    = 7;
  localparam int TOL_W   = 16;
  localparam int ST_W    = 2;
  localparam int IDX_W   = 2;
  localparam int CDATA_W = 16;

  // Fixed-point datapath widths
  localparam int FRAC   = 30;           // Q2.30 fraction bits
  localparam int CF_W   = 25;           // normalized coefficient
  localparam int XI_W   = 32;           // xi, eta
  localparam int J_W    = 27;           // Jacobian entries
  localparam int XE_W   = 34;           // xi*eta in Q4.30
  localparam int F_W    = 29;           // residuals
  localparam int P1_W   = CF_W + XI_W;
  localparam int PXE_W  = 2 * XI_W;
  localparam int P3_W   = CF_W + XE_W;
  localparam int JM_W   = 2 * J_W;
  localparam int DET_W  = 2 * J_W + 1;
  localparam int NP_W   = J_W + F_W;
  localparam int NUM_W  = NP_W + 1;
  localparam int DIV_W  = DET_W + 3;
  localparam int QB     = FRAC + 3;     // quotient bits below saturation
  localparam int QM_W   = QB + 1;       // step magnitude, up to 2^33
  localparam int Q_W    = QM_W + 1;     // signed step

  localparam logic [CMD_W-1:0] CMD_LOAD0 = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD3 = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SOLVE = 3'd4;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic [ST_W-1:0] ST_CONVERGED = 2'd0;
  localparam logic [ST_W-1:0] ST_LIMIT     = 2'd1;
  localparam logic [ST_W-1:0] ST_SINGULAR  = 2'd2;

  localparam logic [IDX_W-1:0] CFG_MAX_ITER = 2'd0;
  localparam logic [IDX_W-1:0] CFG_TOL      = 2'd1;

  localparam logic [IT_W-1:0]  MAX_ITER_RST = 7'd100;
  localparam logic [TOL_W-1:0] TOL_RST      = 16'd1;

  typedef struct packed {
    logic [IT_W-1:0]  max_iter;
    logic [TOL_W-1:0] tol;
  } cfg_t;

  typedef struct packed {
    logic                  done;
    logic [QM_W-1:0]       mag;
    logic signed [Q_W-1:0] q;
  } div_res_t;

endpackage

// File: hw/rtl/qibn_in_if.sv
// ----------------------------------------------------------------------------
// qibn_in_if
// Command channel: vertex loads and solve queries.
// ----------------------------------------------------------------------------
interface qibn_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic [2:0]                    command;
  logic signed [COORD_WIDTH-1:0] coord_x;
  logic signed [COORD_WIDTH-1:0] coord_y;
  logic signed [COORD_WIDTH-1:0] coord_z;
  logic [1:0]                    drop_axis;

  modport source (output valid, command, coord_x, coord_y, coord_z, drop_axis,
                  input ready);
  modport sink   (input valid, command, coord_x, coord_y, coord_z, drop_axis,
                  output ready);
endinterface

// File: hw/rtl/qibn_out_if.sv
// ----------------------------------------------------------------------------
// qibn_out_if
// Result channel: local coordinates, inside flag and status.
// ----------------------------------------------------------------------------
interface qibn_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] xi;
  logic signed [31:0] eta;
  logic               inside_res;
  logic [1:0]         status;

  modport source (output valid, xi, eta, inside_res, status, input ready);
  modport sink   (input valid, xi, eta, inside_res, status, output ready);
endinterface

// File: hw/rtl/qibn_cfg_if.sv
// ----------------------------------------------------------------------------
// qibn_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface qibn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/qibn_front.sv
// ----------------------------------------------------------------------------
// qibn_front
// Stores quad vertices and turns each solve into eight bilinear coefficients.
// ----------------------------------------------------------------------------
module qibn_front import qibn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  qibn_in_if.sink                      in,
  output logic                         push_valid,
  output logic [8*(COORD_WIDTH+3)-1:0] push_data,
  input  logic                         push_ready
);

  localparam int KW = COORD_WIDTH + 3;

  logic signed [COORD_WIDTH-1:0] vtx [4][3];
  logic [1:0] ax_u, ax_w;
  logic signed [COORD_WIDTH-1:0] pu, pw;
  logic signed [KW-1:0] k [8];

  assign in.ready   = push_ready;
  assign push_valid = in.valid && push_ready && (in.command == CMD_SOLVE);

  always_ff @(posedge clk) begin
    if (in.valid && in.ready && (in.command inside {[CMD_LOAD0:CMD_LOAD3]})) begin
      vtx[in.command[1:0]][0] <= in.coord_x;
      vtx[in.command[1:0]][1] <= in.coord_y;
      vtx[in.command[1:0]][2] <= in.coord_z;
    end
  end

  // remaining axes follow the dropped one cyclically
  always_comb begin
    case (in.drop_axis)
      AXIS_Y: begin
        ax_u = 2'd2; ax_w = 2'd0; pu = in.coord_z; pw = in.coord_x;
      end
      AXIS_Z: begin
        ax_u = 2'd0; ax_w = 2'd1; pu = in.coord_x; pw = in.coord_y;
      end
      default: begin
        ax_u = 2'd1; ax_w = 2'd2; pu = in.coord_y; pw = in.coord_z;
      end
    endcase
  end

  always_comb begin
    logic signed [KW-1:0] e0, e1, e2, e3, pp;
    logic [1:0] ax;
    for (int i = 0; i < 2; i++) begin
      ax = (i == 0) ? ax_u : ax_w;
      e0 = KW'(vtx[0][ax]);
      e1 = KW'(vtx[1][ax]);
      e2 = KW'(vtx[2][ax]);
      e3 = KW'(vtx[3][ax]);
      pp = (i == 0) ? KW'(pu) : KW'(pw);
      k[4*i]   = e0 + e1 + e2 + e3 - (pp <<< 2);
      k[4*i+1] = -e0 + e1 + e2 - e3;
      k[4*i+2] = -e0 - e1 + e2 + e3;
      k[4*i+3] = e0 - e1 + e2 - e3;
    end
    for (int n = 0; n < 8; n++) push_data[n*KW +: KW] = k[n];
  end

endmodule

// File: hw/rtl/qibn_queue.sv
// ----------------------------------------------------------------------------
// qibn_queue
// Two-entry job queue between the front and the solver.
// ----------------------------------------------------------------------------
module qibn_queue #(
  parameter int W = 280
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  input  logic [W-1:0] push_data,
  output logic         push_ready,
  output logic         pop_valid,
  output logic [W-1:0] pop_data,
  input  logic         pop
);

  logic [W-1:0] mem [2];
  logic wp, rp;
  logic [1:0] count;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = mem[rp];

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) mem[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push_valid && push_ready) wp <= ~wp;
      if (pop && pop_valid) rp <= ~rp;
      count <= count + 2'(push_valid && push_ready) - 2'(pop && pop_valid);
    end
  end

endmodule

// File: hw/rtl/qibn_div.sv
// ----------------------------------------------------------------------------
// qibn_div
// Radix-2 restoring divider for num*2^30/den, truncated, saturated at 2^33.
// ----------------------------------------------------------------------------
module qibn_div import qibn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic signed [DET_W-1:0] den,
  output div_res_t                res
);

  logic [DIV_W-1:0] r, ud;
  logic [QB-1:0]    qs;
  logic [5:0]       cnt;
  logic             neg, busy, chk, done;
  logic [QM_W-1:0]  mag;
  logic [DIV_W-1:0] rr, dd;

  // first three quotient bits compare against a shifted divisor,
  // the remaining ones shift the remainder
  always_comb begin
    rr = (cnt < 6'd3) ? r : (r << 1);
    case (cnt)
      6'd0:    dd = ud << 2;
      6'd1:    dd = ud << 1;
      default: dd = ud;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        r    <= DIV_W'(num < 0 ? -num : num);
        ud   <= DIV_W'(den < 0 ? -den : den);
        neg  <= (num < 0) != (den < 0);
        qs   <= '0;
        cnt  <= '0;
        busy <= 1'b1;
        chk  <= 1'b1;
      end else if (busy && chk) begin
        chk <= 1'b0;
        if (r >= (ud << 3)) begin
          mag  <= QM_W'(1) << QB;
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (busy) begin
        if (rr >= dd) begin
          r  <= rr - dd;
          qs <= {qs[QB-2:0], 1'b1};
        end else begin
          r  <= rr;
          qs <= {qs[QB-2:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          mag  <= {1'b0, qs[QB-2:0], (rr >= dd)};
        end
      end
    end
  end

  assign res.done = done;
  assign res.mag  = mag;
  assign res.q    = neg ? -Q_W'(mag) : Q_W'(mag);

endmodule

// File: hw/rtl/qibn_back.sv
// ----------------------------------------------------------------------------
// qibn_back
// Newton solver: coefficient scaling, Jacobian, Cramer steps, result register.
// ----------------------------------------------------------------------------
module qibn_back import qibn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         job_valid,
  input  logic [8*(COORD_WIDTH+3)-1:0] job_data,
  output logic                         job_pop,
  qibn_out_if.source                   out
);

  localparam int KW = COORD_WIDTH + 3;
  localparam int EW = (KW > CF_W) ? KW : CF_W + 1;

  localparam logic signed [XI_W-1:0] XI_MAX  = 32'sh7fff_ffff;
  localparam logic signed [XI_W-1:0] XI_MIN  = 32'sh8000_0000;
  localparam logic signed [XI_W-1:0] ONE_Q   = 32'sh4000_0000;
  localparam logic signed [XI_W-1:0] M_ONE_Q = 32'shc000_0000;

  typedef enum logic [11:0] {
    B_IDLE  = 12'b0000_0000_0001,
    B_NORM  = 12'b0000_0000_0010,
    B_LOOP  = 12'b0000_0000_0100,
    B_MUL1  = 12'b0000_0000_1000,
    B_ADD1  = 12'b0000_0001_0000,
    B_MUL2  = 12'b0000_0010_0000,
    B_ADD2  = 12'b0000_0100_0000,
    B_MUL3  = 12'b0000_1000_0000,
    B_ADD3  = 12'b0001_0000_0000,
    B_DIVST = 12'b0010_0000_0000,
    B_DIV   = 12'b0100_0000_0000,
    B_STEP  = 12'b1000_0000_0000
  } bstate_t;

  bstate_t state;

  logic signed [EW-1:0]   kn [8];
  logic signed [CF_W-1:0] cf [8];
  logic                   fits;
  logic signed [XI_W-1:0] xi, eta;
  logic [IT_W-1:0]        it;

  logic signed [P1_W-1:0]  m_k3e, m_k7e, m_k3x, m_k7x, m_k1x, m_k2e, m_k5x, m_k6e;
  logic signed [PXE_W-1:0] m_xe;
  logic signed [J_W-1:0]   j0, j1, j2, j3;
  logic signed [XE_W-1:0]  xe;
  logic signed [F_W-1:0]   fa0, fa1, f0, f1;
  logic signed [P3_W-1:0]  m_k3xe, m_k7xe;
  logic signed [JM_W-1:0]  m03, m21;
  logic signed [NP_W-1:0]  n_a, n_b, n_c, n_d;
  logic signed [DET_W-1:0] det;
  logic signed [NUM_W-1:0] num0, num1;
  logic signed [Q_W-1:0]   d0, d1;
  logic [QM_W-1:0]         d0_mag, d1_mag;
  logic signed [Q_W:0]     sx, se;

  div_res_t res0, res1;
  logic     div_start;
  logic     dn0, dn1;

  logic                   out_valid;
  logic signed [XI_W-1:0] out_xi, out_eta;
  logic                   out_inside;
  logic [ST_W-1:0]        out_status;

  function automatic logic same_top(input logic [EW-CF_W:0] v);
    return (&v) || !(|v);
  endfunction

  always_comb begin
    fits = 1'b1;
    for (int i = 0; i < 8; i++) begin
      cf[i] = kn[i][CF_W-1:0];
      if (!same_top(kn[i][EW-1:CF_W-1])) fits = 1'b0;
    end
  end

  assign job_pop   = (state == B_IDLE) && job_valid && !out_valid;
  assign div_start = (state == B_DIVST) && (det != 0);

  assign sx = (Q_W+1)'(xi) + (Q_W+1)'(d0);
  assign se = (Q_W+1)'(eta) + (Q_W+1)'(d1);

  qibn_div u_div0 (.clk, .rst, .start(div_start), .num(num0), .den(det), .res(res0));
  qibn_div u_div1 (.clk, .rst, .start(div_start), .num(num1), .den(det), .res(res1));

  always_ff @(posedge clk) begin
    logic fin;
    logic [ST_W-1:0] fst;
    fin = 1'b0;
    fst = ST_LIMIT;
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out.valid && out.ready) out_valid <= 1'b0;
      case (state)
        B_IDLE: begin
          if (job_pop) begin
            for (int i = 0; i < 8; i++) begin
              kn[i] <= EW'($signed(job_data[i*KW +: KW]));
            end
            xi    <= '0;
            eta   <= '0;
            it    <= '0;
            state <= B_NORM;
          end
        end
        B_NORM: begin
          // shift all coefficients together until every one fits
          if (fits) state <= B_LOOP;
          else for (int i = 0; i < 8; i++) kn[i] <= kn[i] >>> 1;
        end
        B_LOOP: begin
          if (it == cfg.max_iter) begin
            fin = 1'b1;
            fst = ST_LIMIT;
          end else begin
            state <= B_MUL1;
          end
        end
        B_MUL1: begin
          m_k3e <= cf[3] * eta;
          m_k7e <= cf[7] * eta;
          m_k3x <= cf[3] * xi;
          m_k7x <= cf[7] * xi;
          m_k1x <= cf[1] * xi;
          m_k2e <= cf[2] * eta;
          m_k5x <= cf[5] * xi;
          m_k6e <= cf[6] * eta;
          m_xe  <= xi * eta;
          state <= B_ADD1;
        end
        B_ADD1: begin
          j0  <= J_W'(cf[1] + (m_k3e >>> FRAC));
          j1  <= J_W'(cf[5] + (m_k7e >>> FRAC));
          j2  <= J_W'(cf[2] + (m_k3x >>> FRAC));
          j3  <= J_W'(cf[6] + (m_k7x >>> FRAC));
          xe  <= XE_W'(m_xe >>> FRAC);
          fa0 <= F_W'(cf[0] + (m_k1x >>> FRAC) + (m_k2e >>> FRAC));
          fa1 <= F_W'(cf[4] + (m_k5x >>> FRAC) + (m_k6e >>> FRAC));
          state <= B_MUL2;
        end
        B_MUL2: begin
          m_k3xe <= cf[3] * xe;
          m_k7xe <= cf[7] * xe;
          m03    <= j0 * j3;
          m21    <= j2 * j1;
          state  <= B_ADD2;
        end
        B_ADD2: begin
          f0    <= F_W'(fa0 + (m_k3xe >>> FRAC));
          f1    <= F_W'(fa1 + (m_k7xe >>> FRAC));
          det   <= DET_W'(m03) - DET_W'(m21);
          state <= B_MUL3;
        end
        B_MUL3: begin
          n_a   <= j2 * f1;
          n_b   <= j3 * f0;
          n_c   <= j1 * f0;
          n_d   <= j0 * f1;
          state <= B_ADD3;
        end
        B_ADD3: begin
          num0  <= NUM_W'(n_a) - NUM_W'(n_b);
          num1  <= NUM_W'(n_c) - NUM_W'(n_d);
          state <= B_DIVST;
        end
        B_DIVST: begin
          if (det == 0) begin
            fin = 1'b1;
            fst = ST_SINGULAR;
          end else begin
            dn0   <= 1'b0;
            dn1   <= 1'b0;
            state <= B_DIV;
          end
        end
        B_DIV: begin
          // a saturated quotient finishes early; wait for both dividers
          if (res0.done) dn0 <= 1'b1;
          if (res1.done) dn1 <= 1'b1;
          if ((dn0 || res0.done) && (dn1 || res1.done)) begin
            d0     <= res0.q;
            d1     <= res1.q;
            d0_mag <= res0.mag;
            d1_mag <= res1.mag;
            state  <= B_STEP;
          end
        end
        B_STEP: begin
          // a small step ends the solve and is not applied
          if (d0_mag < QM_W'(cfg.tol) && d1_mag < QM_W'(cfg.tol)) begin
            fin = 1'b1;
            fst = ST_CONVERGED;
          end else begin
            xi  <= (sx > XI_MAX) ? XI_MAX : (sx < XI_MIN) ? XI_MIN : XI_W'(sx);
            eta <= (se > XI_MAX) ? XI_MAX : (se < XI_MIN) ? XI_MIN : XI_W'(se);
            it  <= it + IT_W'(1);
            state <= B_LOOP;
          end
        end
        default: state <= B_IDLE;
      endcase
      if (fin) begin
        out_valid  <= 1'b1;
        out_xi     <= xi;
        out_eta    <= eta;
        out_inside <= (xi >= M_ONE_Q) && (xi <= ONE_Q) &&
                      (eta >= M_ONE_Q) && (eta <= ONE_Q);
        out_status <= fst;
        state      <= B_IDLE;
      end
    end
  end

  assign out.valid      = out_valid;
  assign out.xi         = out_xi;
  assign out.eta        = out_eta;
  assign out.inside_res = out_inside;
  assign out.status     = out_status;

endmodule

// File: hw/rtl/quad_inverse_bilinear_newton_unit.sv
// ----------------------------------------------------------------------------
// quad_inverse_bilinear_newton_unit
// Local (xi, eta) of a point in a bilinear quad by Newton iteration.
// ----------------------------------------------------------------------------
// Channels: in carries commands 0..3 (load vertex) and 4 (solve a query
// point with a dropped axis); out carries one result per solve; cfg writes
// max_iterations (index 0) and step_tolerance (index 1), always ready.
// Vertex loads give no result. A solve is turned into coefficients at
// accept and waits in a two-entry queue, so loads and up to two solves are
// taken while the solver works or a result waits. A solve first scales its
// coefficients (at most COORD_WIDTH-22 shifts), then runs Newton
// iterations, each with a bit-serial step division; the solver takes
// one solve at a time and the division sets the rate. Reset clears the
// queue, the solver and the output register and restores max_iterations
// 100 and step_tolerance 1; vertices hold unknown values until loaded. A
// stalled receiver holds the result; the solver then stops taking jobs and
// the input stalls once the queue is full.
// ----------------------------------------------------------------------------
module quad_inverse_bilinear_newton_unit import qibn_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  qibn_in_if.sink    in,
  qibn_out_if.source out,
  qibn_cfg_if.sink   cfg
);

  localparam int JW = 8 * (COORD_WIDTH + 3);

  cfg_t cfg_reg;
  logic push_valid, push_ready, job_valid, job_pop;
  logic [JW-1:0] push_data, job_data;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.max_iter <= MAX_ITER_RST;
      cfg_reg.tol      <= TOL_RST;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == CFG_MAX_ITER) cfg_reg.max_iter <= cfg.data[IT_W-1:0];
      if (cfg.index == CFG_TOL)      cfg_reg.tol      <= cfg.data[TOL_W-1:0];
    end
  end

  qibn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk, .in,
    .push_valid, .push_data, .push_ready
  );

  qibn_queue #(.W(JW)) u_queue (
    .clk, .rst,
    .push_valid, .push_data, .push_ready,
    .pop_valid(job_valid), .pop_data(job_data), .pop(job_pop)
  );

  qibn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk, .rst, .cfg(cfg_reg),
    .job_valid, .job_data, .job_pop, .out
  );

endmodule

// File: verif/quad_inverse_bilinear_newton_unit_test.sv
// ----------------------------------------------------------------------------
// quad_inverse_bilinear_newton_unit_test
// Self-checking bench for the inverse bilinear Newton unit. A short scripted
// sequence covers zero and extreme quads, every command, every drop axis and
// the register extremes. Random quads with random query points follow, under
// several register settings. Typed script solves are checked against given
// results, the rest against a local fixed-point model of the Newton solver.
// ----------------------------------------------------------------------------
module quad_inverse_bilinear_newton_unit_test;
  import qibn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] xi;
    logic signed [31:0] eta;
    logic               in_quad;
    logic [ST_W-1:0]    status;
  } solve_res_t;

  typedef struct {
    bit                 is_cfg;
    logic [IDX_W-1:0]   idx;
    logic [CDATA_W-1:0] data;
    logic [CMD_W-1:0]   cmd;
    int                 x, y, z;
    logic [AXIS_W-1:0]  axis;
    bit                 typed;
    solve_res_t         res;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qibn_in_if  #(.COORD_WIDTH(32)) in_ch();
  qibn_out_if out_ch();
  qibn_cfg_if cfg_ch();

  quad_inverse_bilinear_newton_unit #(.COORD_WIDTH(32)) u_top (
    .clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model state
  longint      vtx [12];
  int          lim_iter;
  longint      lim_tol;
  solve_res_t  pending_res [$];
  bit          failed = 1'b0;
  bit          idle_on = 1'b1;
  bit          held_once = 1'b0;
  bit          drained_once = 1'b0;
  int          hold_cycles = 0;
  script_row_t script [$];

  function automatic longint qmul30(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint abs64(longint v);
    return v < 0 ? -v : v;
  endfunction

  // num * 2^30 / den, toward zero, magnitude capped at 2^33
  function automatic longint step_div(longint num, longint den);
    bit neg;
    longint unsigned un, ud, q, r;
    neg = (num < 0) != (den < 0);
    un = abs64(num);
    ud = abs64(den);
    q = un / ud;
    r = un % ud;
    if (q >= 8) begin
      q = 64'd1 << 33;
    end else begin
      for (int i = 0; i < 30; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= ud) begin
          r = r - ud;
          q = q | 1;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // update model on an accepted item; returns 1 when a solve result is due
  function automatic bit predict_item(logic [CMD_W-1:0] cmd, int x, int y, int z,
                                      logic [AXIS_W-1:0] axis, output solve_res_t r);
    longint p [3];
    longint k [8];
    longint xi, eta, j0, j1, j2, j3, xe, f0, f1, det, d0, d1, v;
    int d, u, w, s, ax;
    bit fits;
    logic [ST_W-1:0] st;
    p[0] = x; p[1] = y; p[2] = z;
    r = '{default: '0};
    if (cmd <= CMD_LOAD3) begin
      for (int i = 0; i < 3; i++) vtx[cmd * 3 + i] = p[i];
      return 1'b0;
    end
    if (cmd != CMD_SOLVE) return 1'b0;
    d = (axis == 2'd3) ? 0 : axis;
    u = (d + 1) % 3;
    w = (d + 2) % 3;
    for (int i = 0; i < 2; i++) begin
      ax = i ? w : u;
      k[4*i]   = vtx[ax] + vtx[3+ax] + vtx[6+ax] + vtx[9+ax] - 4 * p[ax];
      k[4*i+1] = -vtx[ax] + vtx[3+ax] + vtx[6+ax] - vtx[9+ax];
      k[4*i+2] = -vtx[ax] - vtx[3+ax] + vtx[6+ax] + vtx[9+ax];
      k[4*i+3] = vtx[ax] - vtx[3+ax] + vtx[6+ax] - vtx[9+ax];
    end
    for (s = 0; s < 60; s++) begin
      fits = 1'b1;
      for (int i = 0; i < 8; i++) begin
        v = k[i] >>> s;
        if (v < -(64'sd1 << 24) || v >= (64'sd1 << 24)) fits = 1'b0;
      end
      if (fits) break;
    end
    for (int i = 0; i < 8; i++) k[i] = k[i] >>> s;
    xi = 0;
    eta = 0;
    st = ST_LIMIT;
    for (int it = 0; it < lim_iter; it++) begin
      j0 = k[1] + qmul30(k[3], eta);
      j1 = k[5] + qmul30(k[7], eta);
      j2 = k[2] + qmul30(k[3], xi);
      j3 = k[6] + qmul30(k[7], xi);
      xe = (xi * eta) >>> 30;
      f0 = k[0] + qmul30(k[1], xi) + qmul30(k[2], eta) + qmul30(k[3], xe);
      f1 = k[4] + qmul30(k[5], xi) + qmul30(k[6], eta) + qmul30(k[7], xe);
      det = j0 * j3 - j2 * j1;
      if (det == 0) begin
        st = ST_SINGULAR;
        break;
      end
      d0 = step_div(j2 * f1 - j3 * f0, det);
      d1 = step_div(j1 * f0 - j0 * f1, det);
      if (abs64(d0) < lim_tol && abs64(d1) < lim_tol) begin
        st = ST_CONVERGED;
        break;
      end
      xi = sat_q(xi + d0);
      eta = sat_q(eta + d1);
    end
    r.xi = xi[31:0];
    r.eta = eta[31:0];
    r.in_quad = (xi >= -(64'sd1 << 30) && xi <= (64'sd1 << 30) &&
                 eta >= -(64'sd1 << 30) && eta <= (64'sd1 << 30));
    r.status = st;
    return 1'b1;
  endfunction

  // call at a falling edge; returns at a falling edge with valid still high
  task automatic send_item(logic [CMD_W-1:0] cmd, int x, int y, int z,
                           logic [AXIS_W-1:0] axis, bit typed = 1'b0,
                           solve_res_t typed_res = '{default: '0});
    solve_res_t r;
    while (idle_on && $urandom_range(99) < 33) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.command = cmd;
    in_ch.coord_x = x;
    in_ch.coord_y = y;
    in_ch.coord_z = z;
    in_ch.drop_axis = axis;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_item(cmd, x, y, z, axis, r)) pending_res.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_ch.valid = 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    drain_results();
    cfg_ch.index = idx;
    cfg_ch.data = data;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_MAX_ITER) lim_iter = data[IT_W-1:0];
    else if (idx == CFG_TOL) lim_tol = data[TOL_W-1:0];
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic void add_item(logic [CMD_W-1:0] cmd, int x, int y, int z,
                                   logic [AXIS_W-1:0] axis);
    script_row_t row;
    row = '{default: '0};
    row.cmd = cmd; row.x = x; row.y = y; row.z = z; row.axis = axis;
    script.push_back(row);
  endfunction

  function automatic void add_typed(int x, int y, int z, logic [AXIS_W-1:0] axis,
                                    int rxi, int reta, bit ins, logic [ST_W-1:0] st);
    script_row_t row;
    row = '{default: '0};
    row.cmd = CMD_SOLVE; row.x = x; row.y = y; row.z = z; row.axis = axis;
    row.typed = 1'b1;
    row.res = '{xi: rxi, eta: reta, in_quad: ins, status: st};
    script.push_back(row);
  endfunction

  function automatic void add_reg(logic [IDX_W-1:0] idx, logic [CDATA_W-1:0] data);
    script_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1; row.idx = idx; row.data = data;
    script.push_back(row);
  endfunction

  function automatic int span_rand(int m);
    return int'($urandom_range(0, 2 * m)) - m;
  endfunction

  // one quad in the plane normal to a random axis, then a few queries
  task automatic run_quad(bit noisy, inout int count);
    int c [3];
    int vq [4][3];
    int h, d, u, w, first, nq;
    logic [AXIS_W-1:0] axis;
    axis = AXIS_W'($urandom_range(0, 3));
    d = (axis == 2'd3) ? 0 : axis;
    u = (d + 1) % 3;
    w = (d + 2) % 3;
    h = $urandom_range(1 << 12, 1 << 22);
    for (int i = 0; i < 3; i++) c[i] = span_rand(1 << 22);
    for (int n = 0; n < 4; n++) begin
      vq[n][u] = c[u] + ((n == 0 || n == 3) ? -h : h) + span_rand(h / 4);
      vq[n][w] = c[w] + ((n < 2) ? -h : h) + span_rand(h / 4);
      vq[n][d] = c[d] + span_rand(h);
      if (noisy) for (int i = 0; i < 3; i++) vq[n][i] = $urandom;
    end
    first = $urandom_range(0, 3);
    for (int n = 0; n < 4; n++) begin
      send_item(CMD_W'((first + n) % 4), vq[(first + n) % 4][0], vq[(first + n) % 4][1],
                vq[(first + n) % 4][2], AXIS_W'($urandom_range(0, 3)));
      count++;
    end
    nq = $urandom_range(1, 4);
    for (int q = 0; q < nq; q++) begin
      if ($urandom_range(9) == 0) begin
        send_item(CMD_W'($urandom_range(5, 7)), $urandom, $urandom, $urandom,
                  AXIS_W'($urandom_range(0, 3)));
        count++;
      end
      c[u] = c[u] + span_rand(h + h / 4);
      c[w] = c[w] + span_rand(h + h / 4);
      c[d] = $urandom;
      if (noisy) begin
        c[u] = $urandom;
        c[w] = $urandom;
      end
      send_item(CMD_SOLVE, c[0], c[1], c[2], axis);
      count++;
      c[u] = (vq[0][u] + vq[2][u]) / 2;
      c[w] = (vq[0][w] + vq[2][w]) / 2;
    end
  endtask

  // result side: random back-pressure, long hold on request
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= !idle_on || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    solve_res_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_res.size() == 0) begin
        $display("%0t: result with none expected: xi %h eta %h inside %b status %0d",
                 $realtime, out_ch.xi, out_ch.eta, out_ch.inside_res, out_ch.status);
        failed = 1'b1;
      end else begin
        want = pending_res.pop_front();
        if (out_ch.xi !== want.xi) begin
          $display("%0t: xi expected %h actual %h", $realtime, want.xi, out_ch.xi);
          failed = 1'b1;
        end
        if (out_ch.eta !== want.eta) begin
          $display("%0t: eta expected %h actual %h", $realtime, want.eta, out_ch.eta);
          failed = 1'b1;
        end
        if (out_ch.inside_res !== want.in_quad) begin
          $display("%0t: inside expected %b actual %b", $realtime, want.in_quad,
                   out_ch.inside_res);
          failed = 1'b1;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, want.status,
                   out_ch.status);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    #400_000_000;
    $display("quad_inverse_bilinear_newton_unit test failed");
    $finish;
  end

  initial begin
    int count;
    int iter_set [6] = '{100, 127, 1, 30, 60, 8};
    int tol_set [6] = '{1, 65535, 0, 0, 200, 1};
    in_ch.valid = 1'b0;
    in_ch.command = CMD_LOAD0;
    in_ch.coord_x = '0;
    in_ch.coord_y = '0;
    in_ch.coord_z = '0;
    in_ch.drop_axis = AXIS_X;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_MAX_ITER;
    cfg_ch.data = '0;
    for (int i = 0; i < 12; i++) vtx[i] = 0;
    lim_iter = MAX_ITER_RST;
    lim_tol = TOL_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // all-zero quad: singular at the first step
    for (int n = 0; n < 4; n++) add_item(CMD_W'(n), 0, 0, 0, AXIS_X);
    add_typed(0, 0, 0, AXIS_X, 0, 0, 1'b1, ST_SINGULAR);
    // unit square in the xy plane
    add_item(CMD_LOAD0, -65536, -65536, 0, AXIS_Z);
    add_item(1, 65536, -65536, 0, AXIS_Z);
    add_item(2, 65536, 65536, 0, AXIS_Z);
    add_item(CMD_LOAD3, -65536, 65536, 0, AXIS_Z);
    add_typed(0, 0, 0, AXIS_Z, 0, 0, 1'b1, ST_CONVERGED);
    add_item(CMD_SOLVE, 32768, -32768, 32'h7fffffff, AXIS_Z);
    add_item(CMD_SOLVE, 12345, 32'h80000000, 40000, 2'd3);
    add_item(CMD_SOLVE, 32'h7fffffff, 20000, -30000, AXIS_Y);
    add_item(5, 32'h80000000, 32'h7fffffff, -1, 2'd3);
    add_item(6, 32'h7fffffff, 32'h80000000, 0, AXIS_X);
    add_item(7, -1, 0, 32'h7fffffff, AXIS_Y);
    add_reg(CFG_MAX_ITER, 0);
    add_typed(16384, 16384, 0, AXIS_Z, 0, 0, 1'b1, ST_LIMIT);
    add_reg(CFG_MAX_ITER, 127);
    add_reg(CFG_TOL, 0);
    add_item(CMD_SOLVE, 16384, -50000, 0, AXIS_Z);
    add_reg(CFG_MAX_ITER, 1);
    add_reg(CFG_TOL, 16'hffff);
    add_item(CMD_SOLVE, 32'h7fffffff, 32'h80000000, 0, AXIS_Z);
    add_item(CMD_LOAD0, 32'h80000000, 32'h7fffffff, -1, AXIS_X);
    add_item(CMD_SOLVE, 1000, 32'h80000000, 32'h7fffffff, AXIS_X);
    add_item(CMD_SOLVE, -1, 0, 32'h80000000, AXIS_Y);
    add_reg(CFG_MAX_ITER, MAX_ITER_RST);
    add_reg(CFG_TOL, TOL_RST);

    foreach (script[i]) begin
      if (script[i].is_cfg) write_reg(script[i].idx, script[i].data);
      else send_item(script[i].cmd, script[i].x, script[i].y, script[i].z,
                     script[i].axis, script[i].typed, script[i].res);
    end

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_MAX_ITER, CDATA_W'(iter_set[ph]));
      write_reg(CFG_TOL, CDATA_W'(tol_set[ph]));
      idle_on = (ph != 3);
      count = 0;
      while (count < 150) begin
        run_quad($urandom_range(9) == 0, count);
        // stall the result side long enough to fill the solve queue
        if (ph == 1 && count >= 40 && !held_once) begin
          hold_cycles = 600;
          held_once = 1'b1;
        end
        // let the block empty out before going on
        if (ph == 2 && count >= 70 && !drained_once) begin
          drain_results();
          drained_once = 1'b1;
        end
      end
    end

    drain_results();
    repeat (200) @(negedge clk);
    if (!failed && pending_res.size() == 0) begin
      $display("quad_inverse_bilinear_newton_unit test passed");
    end else begin
      $display("quad_inverse_bilinear_newton_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/qibn_pkg.sv
hw/rtl/qibn_in_if.sv
hw/rtl/qibn_out_if.sv
hw/rtl/qibn_cfg_if.sv
hw/rtl/qibn_front.sv
hw/rtl/qibn_queue.sv
hw/rtl/qibn_div.sv
hw/rtl/qibn_back.sv
hw/rtl/quad_inverse_bilinear_newton_unit.sv
verif/quad_inverse_bilinear_newton_unit_test.sv
